[hdl/line_detect_conv3x3_core_macros.svh]
// assertion macros for the 3x3 line detection core
`ifndef LINE_DETECT_CONV3X3_CORE_MACROS_SVH
`define LINE_DETECT_CONV3X3_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define LDC3_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LDC3_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define LDC3_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ldc3_pkg.sv]
// shared types, constants and helpers of the 3x3 line detection core
package ldc3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int COEF_BITS_DEF  = 6;

    localparam int KERNEL_W   = 54;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int FIFO_DEPTH = 8;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             frame_last;
    } out_t;

    // one window column, top row is the oldest line
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // horizontal line kernel: outer rows -1, middle row 2
    function automatic logic [KERNEL_W-1:0] kernel_reset(int cb);
        logic [KERNEL_W-1:0] k;
        int v;
        k = '0;
        for (int n = 0; n < 9; n++) begin
            v = (n >= 3 && n < 6) ? 2 : -1;
            for (int b = 0; b < cb; b++) begin
                k[n*cb+b] = v[b];
            end
        end
        return k;
    endfunction

endpackage

[hdl/ldc3_ram.sv]
// generic single-write, single-read ram with registered read data
module ldc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/ldc3_cell.sv]
// one window column cell: holds three pixels, shifts them on, registers its column sum
module ldc3_cell #(
    parameter int COEF_BITS = ldc3_pkg::COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  ldc3_pkg::col_t                col_in,
    input  logic [3*COEF_BITS-1:0]        coefs,
    output ldc3_pkg::col_t                col_out,
    output logic signed [COEF_BITS+9:0]   psum
);

    import ldc3_pkg::*;

    localparam int PROD_W = COEF_BITS + 9;
    localparam int PSUM_W = COEF_BITS + 10;

    col_t                     col_reg, col_next;
    logic signed [PSUM_W-1:0] psum_reg, psum_next;
    logic signed [PROD_W-1:0] prod_top, prod_mid, prod_bot;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
        prod_top = $signed(coefs[0*COEF_BITS +: COEF_BITS]) * $signed({1'b0, col_reg.top});
        prod_mid = $signed(coefs[1*COEF_BITS +: COEF_BITS]) * $signed({1'b0, col_reg.mid});
        prod_bot = $signed(coefs[2*COEF_BITS +: COEF_BITS]) * $signed({1'b0, col_reg.bot});
        psum_next = $signed({prod_top[PROD_W-1], prod_top})
                  + $signed({prod_mid[PROD_W-1], prod_mid})
                  + $signed({prod_bot[PROD_W-1], prod_bot});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        psum_reg <= psum_next;
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

[hdl/line_detect_conv3x3_core.sv]
// top level of the streaming 3x3 line detection convolution core
// Takes one 8-bit pixel per clock in raster order and gives one filtered pixel per
// accepted pixel once the first row and one more pixel are in; flush transactions after
// the frame's last pixel drain the remaining image_width + 1 results, the final one marked
// frame_last. Each frame gives image_width * image_height results, border pixels as 0,
// others the flipped-kernel sum clamped to 0..255. Throughput is one transaction per
// clock, set by a three-cell column chain fed from two line rams (one read and one
// write port each). A result passes the s1, s2 and s3 registers into the output
// queue; an eight-entry queue decouples the output side and s_ready drops only
// when the queue plus the results in flight would fill it. Line rams need no clearing
// pass and the core accepts input right after reset. Geometry writes restart the frame;
// the configuration port is always ready, so write it only while the core is idle.
module line_detect_conv3x3_core #(
    parameter int MAX_WIDTH  = ldc3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ldc3_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_BITS  = ldc3_pkg::COEF_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ldc3_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ldc3_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ldc3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ldc3_pkg::KERNEL_W-1:0]     cfg_data
);

    import ldc3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PSUM_W = COEF_BITS + 10;
    localparam int SUM_W  = COEF_BITS + 12;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam logic [KERNEL_W-1:0] KERNEL_RESET = kernel_reset(COEF_BITS);

    function automatic int clamp_dim(int v, int hi);
        if (v < 3) begin
            return 3;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // configuration
    logic [KERNEL_W-1:0] kernel_reg, kernel_next;
    logic [WID_W-1:0]    width_reg, width_next;
    logic [HGT_W-1:0]    height_reg, height_next;
    logic                cfg_fire, restart;

    // frame position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WID_W-1:0] drain_reg, drain_next;
    logic             done_reg, done_next;

    logic s_fire, is_pix, col_last, row_last, drain_last, emit_pix, border_pix;

    // pipeline tags
    logic             s1_upd_reg, s1_upd_next;
    logic             s1_emit_reg, s1_emit_next;
    logic             s1_zero_reg, s1_zero_next;
    logic             s1_last_reg, s1_last_next;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s2_emit_reg, s2_zero_reg, s2_last_reg;
    logic             s3_emit_reg, s3_zero_reg, s3_last_reg;

    // line rams and window chain
    logic [PIX_W-1:0]           line_a_q, line_b_q;
    col_t                       new_col;
    col_t                       cell_col [3];
    logic [3*COEF_BITS-1:0]     cell_coefs [3];
    logic signed [PSUM_W-1:0]   cell_psum [3];
    logic signed [SUM_W-1:0]    total;
    out_t                       push_data;

    // output queue
    out_t             fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W:0]   occupancy;
    logic             push, pop;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_comb begin
        kernel_next = kernel_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_fire) begin
            case (cfg_index)
                REG_KERNEL: kernel_next = cfg_data;
                REG_WIDTH:  width_next  = WID_W'(clamp_dim(int'(cfg_data[DIM_W-1:0]), MAX_WIDTH));
                REG_HEIGHT: height_next = HGT_W'(clamp_dim(int'(cfg_data[DIM_W-1:0]), MAX_HEIGHT));
                default:    kernel_next = kernel_reg;
            endcase
        end
    end

    assign s_fire     = s_valid && s_ready;
    assign is_pix     = (s_data.kind == KIND_PIXEL) && !done_reg;
    assign col_last   = (WID_W'(col_reg) + WID_W'(1)) == width_reg;
    assign row_last   = (HGT_W'(row_reg) + HGT_W'(1)) == height_reg;
    assign drain_last = drain_reg == width_reg;
    assign emit_pix   = (row_reg > ROW_W'(1)) || (row_reg == ROW_W'(1) && col_reg != '0);
    assign border_pix = (col_reg == '0) || (col_reg == COL_W'(1)) || (row_reg == ROW_W'(1));

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        done_next  = done_reg;
        if (restart) begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
            done_next  = 1'b0;
        end else if (s_fire) begin
            if (is_pix) begin
                if (col_last) begin
                    col_next = '0;
                    if (row_last) begin
                        done_next = 1'b1;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else if (done_reg) begin
                if (drain_last) begin
                    col_next   = '0;
                    row_next   = '0;
                    drain_next = '0;
                    done_next  = 1'b0;
                end else begin
                    drain_next = drain_reg + WID_W'(1);
                end
            end
        end
    end

    always_comb begin
        s1_upd_next  = s_fire && is_pix;
        s1_emit_next = s_fire && (is_pix ? emit_pix : done_reg);
        s1_zero_next = is_pix ? border_pix : 1'b1;
        s1_last_next = !is_pix && drain_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_reg  <= KERNEL_RESET;
            width_reg   <= WID_W'(clamp_dim(WIDTH_RESET, MAX_WIDTH));
            height_reg  <= HGT_W'(clamp_dim(HEIGHT_RESET, MAX_HEIGHT));
            col_reg     <= '0;
            row_reg     <= '0;
            drain_reg   <= '0;
            done_reg    <= 1'b0;
            s1_upd_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
            s1_zero_reg <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_emit_reg <= 1'b0;
            s2_zero_reg <= 1'b0;
            s2_last_reg <= 1'b0;
            s3_emit_reg <= 1'b0;
            s3_zero_reg <= 1'b0;
            s3_last_reg <= 1'b0;
        end else begin
            kernel_reg  <= kernel_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            drain_reg   <= drain_next;
            done_reg    <= done_next;
            s1_upd_reg  <= s1_upd_next;
            s1_emit_reg <= s1_emit_next;
            s1_zero_reg <= s1_zero_next;
            s1_last_reg <= s1_last_next;
            s2_emit_reg <= s1_emit_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_last_reg <= s1_last_reg;
            s3_emit_reg <= s2_emit_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_px_reg  <= s_data.pixel;
        s1_col_reg <= col_reg;
    end

    // line a holds the previous row, line b the one before
    ldc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .aclk    (aclk),
        .wr_en   (s1_upd_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_px_reg),
        .rd_addr (col_reg),
        .rd_data (line_a_q)
    );

    ldc3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .aclk    (aclk),
        .wr_en   (s1_upd_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_a_q),
        .rd_addr (col_reg),
        .rd_data (line_b_q)
    );

    assign new_col = '{top: line_b_q, mid: line_a_q, bot: s1_px_reg};

    // cell 2 holds the newest column and pairs with kernel column 0
    for (genvar j = 0; j < 3; j++) begin : g_cell
        localparam int B = 2 - j;

        assign cell_coefs[j] = {kernel_reg[(B)*COEF_BITS +: COEF_BITS],
                                kernel_reg[(3+B)*COEF_BITS +: COEF_BITS],
                                kernel_reg[(6+B)*COEF_BITS +: COEF_BITS]};

        if (j == 2) begin : g_head
            ldc3_cell #(
                .COEF_BITS (COEF_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (s1_upd_reg),
                .col_in   (new_col),
                .coefs    (cell_coefs[j]),
                .col_out  (cell_col[j]),
                .psum     (cell_psum[j])
            );
        end else begin : g_body
            ldc3_cell #(
                .COEF_BITS (COEF_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (s1_upd_reg),
                .col_in   (cell_col[j+1]),
                .coefs    (cell_coefs[j]),
                .col_out  (cell_col[j]),
                .psum     (cell_psum[j])
            );
        end
    end

    always_comb begin
        total = $signed({{2{cell_psum[0][PSUM_W-1]}}, cell_psum[0]})
              + $signed({{2{cell_psum[1][PSUM_W-1]}}, cell_psum[1]})
              + $signed({{2{cell_psum[2][PSUM_W-1]}}, cell_psum[2]});
        push_data.frame_last = s3_last_reg;
        if (s3_zero_reg || total[SUM_W-1]) begin
            push_data.out_pixel = '0;
        end else if (total[SUM_W-2:PIX_W] != '0) begin
            push_data.out_pixel = '1;
        end else begin
            push_data.out_pixel = total[PIX_W-1:0];
        end
    end

    // output queue with credit-based input ready
    assign push      = s3_emit_reg;
    assign pop       = m_valid && m_ready;
    assign m_valid   = cnt_reg != '0;
    assign m_data    = fifo_mem_reg[rd_ptr_reg];
    assign occupancy = {1'b0, cnt_reg} + (CNT_W+1)'(s1_emit_reg)
                     + (CNT_W+1)'(s2_emit_reg) + (CNT_W+1)'(s3_emit_reg);
    assign s_ready   = occupancy < (CNT_W+1)'(FIFO_DEPTH);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/ldc3_checker.sv]
// port-level assertion checker for the 3x3 line detection core, with its bind
`include "line_detect_conv3x3_core_macros.svh"

module ldc3_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           cfg_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ldc3_pkg::out_t m_data
);

    import ldc3_pkg::*;

    `LDC3_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_valid, "result valid right after reset")
    `LDC3_ASSERT_IMP(a_cfg_open, aclk, aresetn, 1'b1, cfg_ready, "config port not ready")
    `LDC3_ASSERT_IMP(a_last_border, aclk, aresetn, m_valid && m_data.frame_last, m_data.out_pixel == '0, "frame end pixel not zero")
    `LDC3_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result transaction changed")

endmodule

bind line_detect_conv3x3_core ldc3_checker u_ldc3_checker (.*);

[verif/tb_top.sv]
// testbench for the 3x3 line detection core: directed table, then random frames checked by a predictor
`timescale 1ns / 1ps

module tb_top;
    import ldc3_pkg::*;

    localparam int COEF_W = COEF_BITS_DEF;
    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;
    localparam int SETTLE = 8;
    localparam int RAND_ITEMS = 750;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam logic [KERNEL_W-1:0] KERNEL_AT_RESET = 54'd18014331971829759;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_t;

    typedef struct {
        step_t                 op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [KERNEL_W-1:0]   data;
        in_t                   item;
        bit                    has_res;
        out_t                  res;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [KERNEL_W-1:0]   cfg_data;

    // predictor state
    logic [PIX_W-1:0]      line_up1 [MAX_W];
    logic [PIX_W-1:0]      line_up2 [MAX_W];
    logic [PIX_W-1:0]      win [9];
    int unsigned           col_pos;
    int unsigned           row_pos;
    int unsigned           out_count;
    bit                    frame_fed;
    logic [KERNEL_W-1:0]   coef_word;
    logic [DIM_W-1:0]      width_raw;
    logic [DIM_W-1:0]      height_raw;

    out_t                  filtered_q [$];
    dir_row_t              dir_tab [$];
    bit                    fixed_on;
    bit                    fixed_has;
    out_t                  fixed_res;
    bit                    tx_burst;
    bit                    rx_burst;
    int unsigned           mism_cnt;
    int unsigned           cycle_cnt;
    int unsigned           rnd_items;

    line_detect_conv3x3_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        out_count = 0;
        frame_fed = 1'b0;
    endfunction

    function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [KERNEL_W-1:0] data);
        case (idx)
            REG_KERNEL: begin
                coef_word = data;
            end
            REG_WIDTH: begin
                width_raw = data[DIM_W-1:0];
                restart_frame();
            end
            REG_HEIGHT: begin
                height_raw = data[DIM_W-1:0];
                restart_frame();
            end
            default: begin
            end
        endcase
    endfunction

    // flipped kernel over the window, clamped to 0..255
    function automatic logic [PIX_W-1:0] window_sum();
        int acc;
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                acc += int'($signed(coef_word[(a*3+b)*COEF_W +: COEF_W]))
                     * int'(win[(2-a)*3 + (2-b)]);
            end
        end
        if (acc < 0) return '0;
        if (acc > 255) return 8'd255;
        return acc[PIX_W-1:0];
    endfunction

    function automatic bit filter_step(input in_t it, output out_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ox;
        int unsigned oy;
        bit emit;
        res = '0;
        emit = 1'b0;
        w = eff_dim(width_raw, MAX_W);
        h = eff_dim(height_raw, MAX_H);
        if (it.kind == KIND_PIXEL && !frame_fed) begin
            c = (col_pos >= w) ? 0 : col_pos;
            r = (row_pos >= h) ? 0 : row_pos;
            for (int k = 0; k < 3; k++) begin
                win[k*3] = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = line_up2[c];
            win[5] = line_up1[c];
            win[8] = it.pixel;
            line_up2[c] = line_up1[c];
            line_up1[c] = it.pixel;
            emit = (r >= 2) || (r == 1 && c >= 1);
            if (emit) begin
                if (c >= 1) begin
                    oy = r - 1;
                    ox = c - 1;
                end else begin
                    oy = r - 2;
                    ox = w - 1;
                end
                if (oy == 0 || oy == h - 1 || ox == 0 || ox == w - 1) begin
                    res.out_pixel = '0;
                end else begin
                    res.out_pixel = window_sum();
                end
                out_count++;
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                if (r + 1 >= h) begin
                    row_pos = r;
                    frame_fed = 1'b1;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        end else if (frame_fed) begin
            // drain: every remaining result is on the border
            emit = 1'b1;
            if (out_count + 1 >= w * h) begin
                res.frame_last = 1'b1;
                restart_frame();
            end else begin
                out_count++;
            end
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mism_cnt++;
        if (mism_cnt <= 10) begin
            $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        end
    endtask

    // sample at the rising edge: results first, then new transactions
    always @(posedge aclk) begin
        out_t want;
        out_t pred;
        bit has;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("unexpected result, out_pixel", -1, int'(m_data.out_pixel));
                end else begin
                    want = filtered_q.pop_front();
                    if (m_data.out_pixel !== want.out_pixel) begin
                        report_mismatch("out_pixel", int'(want.out_pixel),
                                        int'(m_data.out_pixel));
                    end
                    if (m_data.frame_last !== want.frame_last) begin
                        report_mismatch("frame_last", int'(want.frame_last),
                                        int'(m_data.frame_last));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                has = filter_step(s_data, pred);
                if (fixed_on) begin
                    if (fixed_has) filtered_q.push_back(fixed_res);
                end else if (has) begin
                    filtered_q.push_back(pred);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall before each transaction
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        rx_burst = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        end
    end

    task automatic send_item(input in_t it);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid = 1'b0;
        while (filtered_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [KERNEL_W-1:0] data);
        pause_until_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_item(input logic kind, input logic [PIX_W-1:0] px, input bit has,
                            input logic [PIX_W-1:0] exp_px, input logic exp_last);
        dir_row_t r;
        r.op = STEP_ITEM;
        r.idx = REG_KERNEL;
        r.data = '0;
        r.item = {kind, px};
        r.has_res = has;
        r.res = {exp_px, exp_last};
        dir_tab.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [KERNEL_W-1:0] data);
        dir_row_t r;
        r.op = STEP_CFG;
        r.idx = idx;
        r.data = data;
        r.item = '0;
        r.has_res = 1'b0;
        r.res = '0;
        dir_tab.push_back(r);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 8'd255;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [KERNEL_W-1:0] pick_kernel();
        logic [KERNEL_W-1:0] k;
        int unsigned sel;
        int v;
        k = '0;
        sel = $urandom_range(0, 7);
        for (int n = 0; n < 9; n++) begin
            case (sel)
                0: v = int'($urandom_range(0, 63)) - 32;
                1: v = int'($urandom_range(0, 4)) - 2;
                2: v = int'($urandom_range(0, 8)) - 4;
                3: v = 31;
                4: v = -32;
                5: v = -1;
                6: v = 0;
                default: v = (n >= 3 && n < 6) ? 2 : -1;
            endcase
            k[n*COEF_W +: COEF_W] = v[COEF_W-1:0];
        end
        return k;
    endfunction

    function automatic logic [KERNEL_W-1:0] pick_dim(input int unsigned hi);
        logic [KERNEL_W-1:0] d;
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) d = KERNEL_W'($urandom_range(0, 2));
        else if (r == 1) d = KERNEL_W'(3);
        else d = KERNEL_W'($urandom_range(3, hi));
        // junk above the 11-bit field must be dropped
        if ($urandom_range(0, 3) == 0) d[KERNEL_W-1:DIM_W] = (KERNEL_W-DIM_W)'({$urandom, $urandom});
        return d;
    endfunction

    task automatic run_phase(input int unsigned num);
        int unsigned w;
        int unsigned h;
        int unsigned nfr;
        int unsigned cut;
        bit big;
        bit chop;
        bit regrow;
        in_t it;
        pause_until_drained();
        big = (num == 1 || num == 3);
        if ($urandom_range(0, 1) == 1) write_cfg(REG_KERNEL, pick_kernel());
        if (num == 1) begin
            write_cfg(REG_WIDTH, ($urandom_range(0, 1) == 1) ? KERNEL_W'(1024)
                                 : KERNEL_W'($urandom_range(1025, 2047)));
            write_cfg(REG_HEIGHT, KERNEL_W'($urandom_range(0, 3)));
        end else if (num == 3) begin
            write_cfg(REG_HEIGHT, ($urandom_range(0, 1) == 1) ? KERNEL_W'(1024)
                                  : KERNEL_W'($urandom_range(1025, 2047)));
            write_cfg(REG_WIDTH, KERNEL_W'($urandom_range(0, 3)));
        end else begin
            regrow = eff_dim(width_raw, MAX_W) * eff_dim(height_raw, MAX_H) > 400;
            if (regrow || $urandom_range(0, 1) == 1) write_cfg(REG_WIDTH, pick_dim(12));
            if (regrow || $urandom_range(0, 1) == 1) write_cfg(REG_HEIGHT, pick_dim(8));
        end
        if ($urandom_range(0, 7) == 0) write_cfg(REG_NONE, KERNEL_W'({$urandom, $urandom}));
        tx_burst = ($urandom_range(0, 3) == 0);
        nfr = big ? 1 : $urandom_range(1, 3);
        for (int unsigned f = 0; f < nfr; f++) begin
            w = eff_dim(width_raw, MAX_W);
            h = eff_dim(height_raw, MAX_H);
            // large frames are only started, to keep the run short
            chop = big || (f == nfr - 1 && $urandom_range(0, 3) == 0);
            cut = big ? $urandom_range(40, 120) : $urandom_range(0, w * h - 1);
            for (int unsigned p = 0; p < w * h; p++) begin
                if (!big && $urandom_range(0, 29) == 0) begin
                    // early flush, dropped by the core
                    it = {KIND_FLUSH, pick_pixel()};
                    send_item(it);
                end
                it = {KIND_PIXEL, pick_pixel()};
                send_item(it);
                rnd_items++;
                if (chop && p == cut) return;
            end
            for (int unsigned d = 0; d <= w; d++) begin
                it.kind = ($urandom_range(0, 5) == 0) ? KIND_PIXEL : KIND_FLUSH;
                it.pixel = pick_pixel();
                send_item(it);
                rnd_items++;
            end
            if (!big && $urandom_range(0, 4) == 0) begin
                it = {KIND_FLUSH, pick_pixel()};
                send_item(it);
            end
        end
    endtask

    initial begin
        int unsigned num;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_KERNEL;
        cfg_data = '0;
        fixed_on = 1'b0;
        fixed_has = 1'b0;
        fixed_res = '0;
        tx_burst = 1'b0;
        mism_cnt = 0;
        cycle_cnt = 0;
        rnd_items = 0;
        for (int i = 0; i < MAX_W; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        restart_frame();
        coef_word = KERNEL_AT_RESET;
        width_raw = DIM_W'(WIDTH_RESET);
        height_raw = DIM_W'(HEIGHT_RESET);

        // first row of a 640-wide frame gives nothing, early flush is dropped
        add_item(KIND_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0);
        add_item(KIND_FLUSH, 8'hA5, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd128, 1'b0, 8'd0, 1'b0);
        // 3x3 frame with the horizontal kernel: only the center is not border
        add_cfg(REG_WIDTH, KERNEL_W'(3));
        add_cfg(REG_HEIGHT, KERNEL_W'(3));
        add_item(KIND_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd255, 1'b1, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd255, 1'b1, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd0, 1'b1, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd0, 1'b1, 8'd0, 1'b0);
        add_item(KIND_PIXEL, 8'd0, 1'b1, 8'd255, 1'b0);
        add_item(KIND_FLUSH, 8'd0, 1'b1, 8'd0, 1'b0);
        // pixel during drain counts as flush
        add_item(KIND_PIXEL, 8'h5A, 1'b1, 8'd0, 1'b0);
        add_item(KIND_FLUSH, 8'hFF, 1'b1, 8'd0, 1'b0);
        add_item(KIND_FLUSH, 8'd0, 1'b1, 8'd0, 1'b1);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        fixed_on = 1'b1;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == STEP_CFG) begin
                write_cfg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                fixed_has = dir_tab[i].has_res;
                fixed_res = dir_tab[i].res;
                send_item(dir_tab[i].item);
            end
        end
        pause_until_drained();
        fixed_on = 1'b0;

        num = 0;
        while (rnd_items < RAND_ITEMS) begin
            run_phase(num);
            num++;
        end

        s_valid = 1'b0;
        while (filtered_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mism_cnt == 0 && filtered_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
